// ===== design/lthc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lthc_pkg
// Shared types and constants of the tagged handle cache: entry layout,
// request kinds, register map and memory control group.
// ----------------------------------------------------------------------------
package lthc_pkg;

    localparam int TS_W     = 16;
    localparam int VAR_W    = 8;
    localparam int LEVEL_W  = 4;
    localparam int TAG_W    = 32;
    localparam int HANDLE_W = 32;
    localparam int CAP_W    = 5;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd12;

    // request kinds
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_FILL   = 1'b1;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_CAPACITY    = 2'd0;
    localparam logic [1:0] REG_REFINEMENT  = 2'd1;
    localparam logic [1:0] REG_COMPRESSION = 2'd2;
    localparam logic [1:0] REG_REGION      = 2'd3;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TAG_W-1:0]    region;
        logic [LEVEL_W-1:0]  compression;
        logic [LEVEL_W-1:0]  refinement;
        logic [VAR_W-1:0]    variable;
        logic [TS_W-1:0]     timestep;
    } entry_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctrl_t;

endpackage
`default_nettype wire

// ===== design/lru_tagged_handle_cache_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lru_tagged_handle_cache_top
// Fully associative cache of data handles with least recently used order.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  s_axis    in         tvalid/tready                tdata: timestep, variable_id,
//                                                    fill_handle; tuser: kind
//  m_axis    out        tvalid/tready                tdata: found_handle,
//                                                    evicted_handle; tuser: hit, evicted
//  apb       in         psel/penable/pwrite/pready   paddr, pwdata, prdata
//
//  a lookup scans the entry memory in recency order, one entry per cycle
//  on its read port
//  a fill that evicts makes one extra read of the victim
//  one request is worked on at a time; a new request is taken while the
//  previous result still waits in the output register
//  reset empties the cache and sets the registers to their reset values
// ----------------------------------------------------------------------------
module lru_tagged_handle_cache_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    // timestep [15:0], variable_id [23:16], fill_handle [55:24]
    input  wire  [55:0] s_axis_tdata,
    // kind [0]
    input  wire  [0:0]  s_axis_tuser,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // found_handle [31:0], evicted_handle [63:32]
    output logic [63:0] m_axis_tdata,
    // hit [0], evicted [1]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = (CW > lthc_pkg::CAP_W) ? CW : lthc_pkg::CAP_W;
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ENTRIES);
    localparam logic [EW-1:0] CAP_MAX   = EW'(MAX_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVICT_RD,
        ST_FILL_WR,
        ST_DONE
    } state_t;

    // configuration registers
    logic [lthc_pkg::CAP_W-1:0]    cap_reg;
    logic [lthc_pkg::LEVEL_W-1:0]  refine_reg;
    logic [lthc_pkg::LEVEL_W-1:0]  compress_reg;
    logic [lthc_pkg::TAG_W-1:0]    region_reg;

    state_t                        state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 pos_reg, pos_next;
    logic [CW-1:0]                 cmp_pos_reg, cmp_pos_next;
    logic [IW-1:0]                 cmp_slot_reg, cmp_slot_next;
    logic                          cmp_valid_reg, cmp_valid_next;
    logic                          evict_reg, evict_next;

    logic                          kind_reg, kind_next;
    logic [lthc_pkg::TS_W-1:0]     ts_reg, ts_next;
    logic [lthc_pkg::VAR_W-1:0]    var_reg, var_next;
    logic [lthc_pkg::HANDLE_W-1:0] fh_reg, fh_next;

    logic                          res_hit_reg, res_hit_next;
    logic [lthc_pkg::HANDLE_W-1:0] res_found_reg, res_found_next;
    logic                          res_evicted_reg, res_evicted_next;
    logic [lthc_pkg::HANDLE_W-1:0] res_evh_reg, res_evh_next;

    logic                          out_valid_reg, out_valid_next;
    logic                          out_hit_reg, out_hit_next;
    logic [lthc_pkg::HANDLE_W-1:0] out_found_reg, out_found_next;
    logic                          out_evicted_reg, out_evicted_next;
    logic [lthc_pkg::HANDLE_W-1:0] out_evh_reg, out_evh_next;

    // recency list: position 0 holds the slot of the most recent entry,
    // positions at and above the count hold free slots
    logic [IW-1:0]                 order_reg  [MAX_ENTRIES];
    logic [IW-1:0]                 order_next [MAX_ENTRIES];

    logic [IW-1:0]                 ord_idx;
    logic [IW-1:0]                 ord_sel;
    logic                          rot_en;
    logic [CW-1:0]                 rot_k;
    logic [IW-1:0]                 rot_head;
    logic [CW-1:0]                 fill_k;
    logic [EW-1:0]                 eff_cap;
    logic                          key_match;
    logic                          s_accept;
    logic                          cfg_write;

    lthc_pkg::ram_ctrl_t           ram_ctrl;
    logic [IW-1:0]                 ram_waddr;
    logic [IW-1:0]                 ram_raddr;
    lthc_pkg::entry_t              ram_wdata;
    lthc_pkg::entry_t              ram_rdata;

    lthc_entry_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (IW)
    ) u_ram (
        .clk   (clk),
        .ctrl  (ram_ctrl),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            lthc_pkg::REG_CAPACITY:    prdata = {27'd0, cap_reg};
            lthc_pkg::REG_REFINEMENT:  prdata = {28'd0, refine_reg};
            lthc_pkg::REG_COMPRESSION: prdata = {28'd0, compress_reg};
            lthc_pkg::REG_REGION:      prdata = region_reg;
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= lthc_pkg::CAPACITY_RESET;
            refine_reg   <= '0;
            compress_reg <= '0;
            region_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                lthc_pkg::REG_CAPACITY:    cap_reg      <= pwdata[4:0];
                lthc_pkg::REG_REFINEMENT:  refine_reg   <= pwdata[3:0];
                lthc_pkg::REG_COMPRESSION: compress_reg <= pwdata[3:0];
                lthc_pkg::REG_REGION:      region_reg   <= pwdata;
                default:                   cap_reg      <= cap_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // request datapath and control
    // ------------------------------------------------------------------------
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // zero capacity counts as one, anything above the store as full size
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = EW'(1);
        end
        else if (EW'(cap_reg) > CAP_MAX)
        begin
            eff_cap = CAP_MAX;
        end
        else
        begin
            eff_cap = EW'(cap_reg);
        end
    end

    // victim sits at the oldest position, otherwise take the first free slot
    assign fill_k  = evict_reg ? (count_reg - CW'(1)) : count_reg;
    assign ord_sel = order_reg[ord_idx];

    assign key_match = (ram_rdata.timestep == ts_reg) &&
                       (ram_rdata.variable == var_reg) &&
                       (ram_rdata.refinement == refine_reg) &&
                       (ram_rdata.compression == compress_reg) &&
                       (ram_rdata.region == region_reg);

    assign ram_wdata.handle      = fh_reg;
    assign ram_wdata.region      = region_reg;
    assign ram_wdata.compression = compress_reg;
    assign ram_wdata.refinement  = refine_reg;
    assign ram_wdata.variable    = var_reg;
    assign ram_wdata.timestep    = ts_reg;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        pos_next         = pos_reg;
        cmp_pos_next     = cmp_pos_reg;
        cmp_slot_next    = cmp_slot_reg;
        cmp_valid_next   = cmp_valid_reg;
        evict_next       = evict_reg;
        kind_next        = kind_reg;
        ts_next          = ts_reg;
        var_next         = var_reg;
        fh_next          = fh_reg;
        res_hit_next     = res_hit_reg;
        res_found_next   = res_found_reg;
        res_evicted_next = res_evicted_reg;
        res_evh_next     = res_evh_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_hit_next     = out_hit_reg;
        out_found_next   = out_found_reg;
        out_evicted_next = out_evicted_reg;
        out_evh_next     = out_evh_reg;

        ord_idx        = pos_reg[IW-1:0];
        ram_ctrl.wr_en = 1'b0;
        ram_ctrl.rd_en = 1'b0;
        ram_raddr      = ord_sel;
        ram_waddr      = ord_sel;
        rot_en         = 1'b0;
        rot_k          = fill_k;
        rot_head       = ord_sel;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    kind_next        = s_axis_tuser[0];
                    ts_next          = s_axis_tdata[15:0];
                    var_next         = s_axis_tdata[23:16];
                    fh_next          = s_axis_tdata[55:24];
                    res_hit_next     = 1'b0;
                    res_found_next   = '0;
                    res_evicted_next = 1'b0;
                    res_evh_next     = '0;
                    pos_next         = '0;
                    cmp_valid_next   = 1'b0;
                    evict_next       = 1'b0;
                    if (s_axis_tuser[0] == lthc_pkg::KIND_LOOKUP)
                    begin
                        state_next = (count_reg == '0) ? ST_DONE : ST_SCAN;
                    end
                    else if ((EW'(count_reg) >= eff_cap) && (count_reg != '0))
                    begin
                        evict_next = 1'b1;
                        state_next = ST_EVICT_RD;
                    end
                    else
                    begin
                        state_next = ST_FILL_WR;
                    end
                end
            end

            ST_SCAN:
            begin
                // read of one position overlaps the compare of the previous
                ord_idx        = pos_reg[IW-1:0];
                cmp_valid_next = (pos_reg < count_reg);
                if (pos_reg < count_reg)
                begin
                    ram_ctrl.rd_en = 1'b1;
                    ram_raddr      = ord_sel;
                    pos_next       = pos_reg + CW'(1);
                    cmp_pos_next   = pos_reg;
                    cmp_slot_next  = ord_sel;
                end
                if (cmp_valid_reg)
                begin
                    if (key_match)
                    begin
                        rot_en         = 1'b1;
                        rot_k          = cmp_pos_reg;
                        rot_head       = cmp_slot_reg;
                        res_hit_next   = 1'b1;
                        res_found_next = ram_rdata.handle;
                        cmp_valid_next = 1'b0;
                        state_next     = ST_DONE;
                    end
                    else if (cmp_pos_reg == (count_reg - CW'(1)))
                    begin
                        cmp_valid_next = 1'b0;
                        state_next     = ST_DONE;
                    end
                end
            end

            ST_EVICT_RD:
            begin
                ord_idx        = fill_k[IW-1:0];
                ram_ctrl.rd_en = 1'b1;
                ram_raddr      = ord_sel;
                state_next     = ST_FILL_WR;
            end

            ST_FILL_WR:
            begin
                ord_idx        = fill_k[IW-1:0];
                ram_ctrl.wr_en = 1'b1;
                ram_waddr      = ord_sel;
                rot_en         = 1'b1;
                rot_k          = fill_k;
                rot_head       = ord_sel;
                if (evict_reg)
                begin
                    res_evicted_next = 1'b1;
                    res_evh_next     = ram_rdata.handle;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_hit_next     = res_hit_reg;
                    out_found_next   = res_found_reg;
                    out_evicted_next = res_evicted_reg;
                    out_evh_next     = res_evh_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // move the chosen slot to the front, shifting the younger ones back
    always_comb
    begin
        for (int p = 0; p < MAX_ENTRIES; p++)
        begin
            order_next[p] = order_reg[p];
        end
        if (rot_en)
        begin
            order_next[0] = rot_head;
            for (int p = 1; p < MAX_ENTRIES; p++)
            begin
                if (CW'(p) <= rot_k)
                begin
                    order_next[p] = order_reg[p-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            pos_reg         <= '0;
            cmp_pos_reg     <= '0;
            cmp_slot_reg    <= '0;
            cmp_valid_reg   <= 1'b0;
            evict_reg       <= 1'b0;
            kind_reg        <= lthc_pkg::KIND_LOOKUP;
            ts_reg          <= '0;
            var_reg         <= '0;
            fh_reg          <= '0;
            res_hit_reg     <= 1'b0;
            res_found_reg   <= '0;
            res_evicted_reg <= 1'b0;
            res_evh_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_hit_reg     <= 1'b0;
            out_found_reg   <= '0;
            out_evicted_reg <= 1'b0;
            out_evh_reg     <= '0;
            for (int p = 0; p < MAX_ENTRIES; p++)
            begin
                order_reg[p] <= IW'(p);
            end
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            pos_reg         <= pos_next;
            cmp_pos_reg     <= cmp_pos_next;
            cmp_slot_reg    <= cmp_slot_next;
            cmp_valid_reg   <= cmp_valid_next;
            evict_reg       <= evict_next;
            kind_reg        <= kind_next;
            ts_reg          <= ts_next;
            var_reg         <= var_next;
            fh_reg          <= fh_next;
            res_hit_reg     <= res_hit_next;
            res_found_reg   <= res_found_next;
            res_evicted_reg <= res_evicted_next;
            res_evh_reg     <= res_evh_next;
            out_valid_reg   <= out_valid_next;
            out_hit_reg     <= out_hit_next;
            out_found_reg   <= out_found_next;
            out_evicted_reg <= out_evicted_next;
            out_evh_reg     <= out_evh_next;
            for (int p = 0; p < MAX_ENTRIES; p++)
            begin
                order_reg[p] <= order_next[p];
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_evh_reg, out_found_reg};
    assign m_axis_tuser  = {out_evicted_reg, out_hit_reg};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("entry count above store size");

    a_scan_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> $stable(count_reg))
        else $error("lookup changed entry count");

    a_hit_not_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("result flags both hit and eviction");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[31:0] == '0))
        else $error("non-hit result carries a found handle");

endmodule
`default_nettype wire

// ===== design/lthc_entry_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lthc_entry_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lthc_entry_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire                      clk,
    input  lthc_pkg::ram_ctrl_t      ctrl,
    input  wire  [AW-1:0]            waddr,
    input  lthc_pkg::entry_t         wdata,
    input  wire  [AW-1:0]            raddr,
    output lthc_pkg::entry_t         rdata
);

    lthc_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (ctrl.rd_en)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire
